>>> design/horton_infiltration_cell_update_defines.svh
// Assertion macros shared by the infiltration cell update RTL.
// No dependencies; the including module must have i_clk and i_rst_n.
`ifndef HORTON_INFILTRATION_CELL_UPDATE_DEFINES_SVH
`define HORTON_INFILTRATION_CELL_UPDATE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HICU_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HICU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/hicu_pkg.sv
// Types, register codes and the integer exponential table for the infiltration update.
// No dependencies.
package hicu_pkg;

    localparam int EXP_LEN   = 23;
    localparam int SER_TERMS = 12;

    localparam logic [1:0] CFG_ENABLE  = 2'd0;
    localparam logic [1:0] CFG_TSTEP   = 2'd1;
    localparam logic [1:0] CFG_DRY_THR = 2'd2;

    localparam logic [30:0] MASK31   = 31'h7FFF_FFFF;
    localparam logic [31:0] TS_RESET = 32'h0001_0000;

    typedef logic [EXP_LEN-1:0][32:0] t_exp_tab;

    // Truncated series for exp(-f), f in Q0.32, result Q1.32.
    function automatic logic [32:0] exp_frac_c(input logic [31:0] f);
        logic [63:0]  sum;
        logic [63:0]  term;
        logic [127:0] prod;
        logic         done;
        sum  = 64'h1_0000_0000;
        term = 64'h1_0000_0000;
        done = 1'b0;
        for (int j = 1; j < 40; j++) begin
            if (!done) begin
                prod = 128'(term) * 128'(f);
                term = 64'(prod >> 32) / 64'(j);
                if (term == 64'd0) begin
                    done = 1'b1;
                end else if ((j & 1) != 0) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
        end
        return 33'(sum);
    endfunction

    function automatic t_exp_tab build_exp_tab();
        t_exp_tab     tab;
        logic [32:0]  h;
        logic [32:0]  e1;
        logic [127:0] prod;
        h    = exp_frac_c(32'h8000_0000);
        prod = 128'(h) * 128'(h) + 128'h8000_0000;
        e1   = 33'(prod >> 32);
        tab[0] = 33'h1_0000_0000;
        for (int n = 1; n < EXP_LEN; n++) begin
            prod   = 128'(tab[n-1]) * 128'(e1) + 128'h8000_0000;
            tab[n] = 33'(prod >> 32);
        end
        return tab;
    endfunction

    localparam t_exp_tab EXP_TAB = build_exp_tab();

    // Everything one item carries down the pipeline.
    typedef struct packed {
        logic [15:0]        cell_idx;
        logic               excl;
        logic               applied;
        logic signed [31:0] z;
        logic signed [31:0] zb;
        logic signed [31:0] fc;
        logic [30:0]        f0;
        logic [30:0]        k;
        logic [15:0]        qe_cell;
        logic               dneg;
        logic [30:0]        mag;
        logic signed [33:0] h;
        logic [31:0]        t;
        logic [30:0]        n;
        logic [31:0]        f;
        logic [31:0]        term;
        logic [32:0]        sum;
        logic [31:0]        p;
        logic [31:0]        qe;
        logic [32:0]        e;
        logic [30:0]        adj;
        logic [30:0]        rate;
        logic [46:0]        lraw;
        logic [31:0]        new_z;
        logic [30:0]        wdep;
        logic               dry;
        logic [63:0]        rem;
        logic               sat;
        logic [30:0]        quo;
    } t_item;

    typedef struct packed {
        logic [15:0] cell_out;
        logic        applied;
        logic [31:0] new_level;
        logic [30:0] water_depth;
        logic        is_dry;
        logic [30:0] achieved_rate;
    } t_res;

endpackage

>>> design/horton_infiltration_cell_update.sv
// Horton infiltration update for one mesh cell per request, with a per-cell wetting-time store.
// Depends on hicu_pkg and horton_infiltration_cell_update_defines.svh.
`include "horton_infiltration_cell_update_defines.svh"

// One request per clock is accepted while the pipeline is not held or clearing, and one
// result per request is delivered, in order. The pipeline has 74 stages (a memory read and
// write-back of the wetting time, a 32x31 multiply for k*t, eleven three-stage terms of the
// exp series, the table scaling, rate and loss multiplies, and a 31-stage restoring divider
// for the achieved rate), followed by the output register. The wetting-time store is one
// single-port-write memory of CELLS words; back-to-back requests to the same cell are
// forwarded. After reset the store is cleared one word per cycle, so no request is taken
// until every word is cleared; configuration writes are taken at any time. A two-entry output
// buffer keeps results while the consumer stalls; the pipeline then holds.
module horton_infiltration_cell_update
    import hicu_pkg::*;
#(
    parameter int CELLS = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wen,
    input  logic [1:0]  i_cfg_index,
    input  logic [30:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_cell_index,
    input  logic        i_excluded,
    input  logic signed [31:0] i_surface_level,
    input  logic signed [31:0] i_bed_level,
    input  logic signed [31:0] i_final_rate,
    input  logic [30:0] i_initial_rate,
    input  logic [30:0] i_decay_rate,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_cell_out,
    output logic        o_applied,
    output logic signed [31:0] o_new_level,
    output logic [30:0] o_water_depth,
    output logic        o_is_dry,
    output logic [30:0] o_achieved_rate
);

    localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam logic [32:0] CELLS_RECIP = 33'h1_0000_0000 / CELLS;
    localparam logic [24:0] CELLS_V     = 25'(CELLS);

    localparam int ST_PRE   = 1;
    localparam int ST_T     = 2;
    localparam int ST_X     = 3;
    localparam int ST_SER   = 4;
    localparam int ST_EXP   = ST_SER + 3 * (SER_TERMS - 1);
    localparam int ST_ADJ   = ST_EXP + 1;
    localparam int ST_RATE  = ST_EXP + 2;
    localparam int ST_LRAW  = ST_EXP + 3;
    localparam int ST_LOSS  = ST_EXP + 4;
    localparam int ST_DSAT  = ST_EXP + 5;
    localparam int ST_DIV   = ST_EXP + 6;
    localparam int NST      = ST_DIV + 31;

    // configuration
    logic        r_enable;
    logic [30:0] r_ts;
    logic [30:0] r_dt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_ts     <= TS_RESET[30:0];
            r_dt     <= '0;
        end else if (i_cfg_wen) begin
            unique case (i_cfg_index)
                CFG_ENABLE:  r_enable <= i_cfg_wdata[0];
                CFG_TSTEP:   r_ts     <= i_cfg_wdata;
                CFG_DRY_THR: r_dt     <= i_cfg_wdata;
                default:     r_enable <= r_enable;
            endcase
        end
    end

    // pipeline
    t_item       r_st [NST];
    t_item       n_st [NST];
    logic        r_vld [NST];
    logic        w_adv;
    logic        r_skid_vld;
    logic        r_out_vld;
    logic        r_clearing;
    logic [AW-1:0] r_clr_addr;

    assign w_adv      = !r_skid_vld;
    assign o_in_ready = w_adv && !r_clearing;

    // wetting-time store and its forwarding register
    logic [31:0]   r_mem [CELLS];
    logic [31:0]   r_rd_data;
    logic [AW-1:0] r_s1_slot;
    logic [AW-1:0] w_slot;
    logic          r_lw_vld;
    logic [AW-1:0] r_lw_addr;
    logic [31:0]   r_lw_data;
    logic [31:0]   w_t;
    logic [32:0]   w_tsum;
    logic [31:0]   w_nt;
    logic          w_wr_en;
    logic [40:0]   w_qprod;
    logic [15:0]   w_rem0;
    logic [15:0]   w_rem;

    // cell index modulo CELLS, from the quotient estimate taken at the input stage
    always_comb begin
        w_qprod = 41'(r_st[0].qe_cell) * 41'(CELLS_V);
        w_rem0  = r_st[0].cell_idx - w_qprod[15:0];
        w_rem   = ({9'd0, w_rem0} >= CELLS_V) ? (w_rem0 - CELLS_V[15:0]) : w_rem0;
        w_slot  = AW'(w_rem);
    end

    assign w_t     = (r_lw_vld && (r_lw_addr == r_s1_slot)) ? r_lw_data : r_rd_data;
    assign w_tsum  = 33'(w_t) + 33'(r_ts);
    assign w_nt    = w_tsum[32] ? 32'hFFFF_FFFF : w_tsum[31:0];
    assign w_wr_en = w_adv && r_vld[ST_PRE] && r_st[ST_PRE].applied && !r_clearing;

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_addr] <= '0;
        end else if (w_wr_en) begin
            r_mem[r_s1_slot] <= w_nt;
        end
        if (w_adv) begin
            r_rd_data <= r_mem[w_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
            r_lw_vld   <= 1'b0;
        end else begin
            if (r_clearing) begin
                if (r_clr_addr == AW'(CELLS - 1)) begin
                    r_clearing <= 1'b0;
                end
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (w_adv) begin
                r_lw_vld <= w_wr_en;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_lw_addr <= r_s1_slot;
            r_lw_data <= w_nt;
            r_s1_slot <= w_slot;
        end
    end

    // input stage
    logic [48:0] w_cprod;
    always_comb begin
        w_cprod          = 49'(i_cell_index) * 49'(CELLS_RECIP);
        n_st[0]          = '0;
        n_st[0].cell_idx = i_cell_index;
        n_st[0].excl     = i_excluded;
        n_st[0].z        = i_surface_level;
        n_st[0].zb       = i_bed_level;
        n_st[0].fc       = i_final_rate;
        n_st[0].f0       = i_initial_rate;
        n_st[0].k        = i_decay_rate;
        n_st[0].qe_cell  = w_cprod[47:32];
    end

    for (genvar s = 1; s < NST; s++) begin : g_stage
        if (s == ST_PRE) begin : g_pre
            logic signed [32:0] diff;
            always_comb begin
                n_st[s]         = r_st[s-1];
                n_st[s].h       = 34'(r_st[s-1].z) - 34'(r_st[s-1].zb);
                n_st[s].applied = r_enable && !r_st[s-1].excl && (r_st[s-1].fc > 32'sd0)
                                  && (n_st[s].h > 34'sd0);
                diff            = $signed({2'b00, r_st[s-1].f0}) - 33'(r_st[s-1].fc);
                n_st[s].dneg    = diff[32];
                n_st[s].mag     = diff[32] ? 31'(-diff) : diff[30:0];
            end
        end else if (s == ST_T) begin : g_t
            always_comb begin
                n_st[s]   = r_st[s-1];
                n_st[s].t = w_t;
            end
        end else if (s == ST_X) begin : g_x
            logic [62:0] x;
            always_comb begin
                x            = 63'(r_st[s-1].k) * 63'(r_st[s-1].t);
                n_st[s]      = r_st[s-1];
                n_st[s].n    = x[62:32];
                n_st[s].f    = x[31:0];
                n_st[s].term = x[31:0];
                n_st[s].sum  = 33'h1_0000_0000 - 33'(x[31:0]);
            end
        end else if (s < ST_EXP) begin : g_ser
            localparam int J     = (s - ST_SER) / 3 + 2;
            localparam int PHASE = (s - ST_SER) % 3;
            localparam logic [32:0] RECIP = 33'h1_0000_0000 / J;
            logic [63:0] prod;
            logic [31:0] r;
            logic [31:0] q;
            always_comb begin
                n_st[s] = r_st[s-1];
                prod    = '0;
                r       = '0;
                q       = '0;
                unique case (PHASE)
                    0: begin
                        prod      = 64'(r_st[s-1].term) * 64'(r_st[s-1].f);
                        n_st[s].p = prod[63:32];
                    end
                    1: begin
                        prod       = 64'(r_st[s-1].p) * 64'(RECIP[31:0]);
                        n_st[s].qe = prod[63:32];
                    end
                    default: begin
                        prod = 64'(r_st[s-1].qe) * 64'(J);
                        r    = r_st[s-1].p - prod[31:0];
                        q    = (r >= 32'(J)) ? r_st[s-1].qe + 32'd1 : r_st[s-1].qe;
                        n_st[s].term = q;
                        n_st[s].sum  = ((J % 2) == 1) ? r_st[s-1].sum - 33'(q)
                                                       : r_st[s-1].sum + 33'(q);
                    end
                endcase
            end
        end else if (s == ST_EXP) begin : g_exp
            logic [65:0] prod;
            always_comb begin
                prod    = 66'(EXP_TAB[r_st[s-1].n[4:0]]) * 66'(r_st[s-1].sum)
                          + 66'h8000_0000;
                n_st[s] = r_st[s-1];
                n_st[s].e = (r_st[s-1].n >= 31'(EXP_LEN)) ? 33'd0 : prod[64:32];
            end
        end else if (s == ST_ADJ) begin : g_adj
            logic [64:0] prod;
            always_comb begin
                prod        = 65'(r_st[s-1].mag) * 65'(r_st[s-1].e) + 65'h8000_0000;
                n_st[s]     = r_st[s-1];
                n_st[s].adj = prod[62:32];
            end
        end else if (s == ST_RATE) begin : g_rate
            logic [32:0] rs;
            always_comb begin
                rs = r_st[s-1].dneg ? 33'(r_st[s-1].fc) - {2'b00, r_st[s-1].adj}
                                    : 33'(r_st[s-1].fc) + {2'b00, r_st[s-1].adj};
                n_st[s]      = r_st[s-1];
                n_st[s].rate = rs[32] ? 31'd0 : rs[30:0];
            end
        end else if (s == ST_LRAW) begin : g_lraw
            logic [62:0] prod;
            always_comb begin
                prod         = 63'(r_st[s-1].rate) * 63'(r_ts) + 63'h8000;
                n_st[s]      = r_st[s-1];
                n_st[s].lraw = prod[62:16];
            end
        end else if (s == ST_LOSS) begin : g_loss
            logic [32:0] hu;
            logic [32:0] loss;
            logic [32:0] depth;
            always_comb begin
                hu    = r_st[s-1].h[32:0];
                loss  = (r_st[s-1].lraw > 47'(hu)) ? hu : r_st[s-1].lraw[32:0];
                depth = hu - loss;
                n_st[s]       = r_st[s-1];
                n_st[s].new_z = r_st[s-1].z - loss[31:0];
                n_st[s].wdep  = (depth[32:31] != 2'b00) ? MASK31 : depth[30:0];
                n_st[s].dry   = depth <= 33'(r_dt);
                n_st[s].rem   = 64'(loss) << 16;
            end
        end else if (s == ST_DSAT) begin : g_dsat
            always_comb begin
                n_st[s]     = r_st[s-1];
                n_st[s].sat = (r_ts != 31'd0) && (r_st[s-1].rem >= (64'(r_ts) << 31));
                n_st[s].quo = '0;
            end
        end else begin : g_div
            localparam int B = 30 - (s - ST_DIV);
            logic [63:0] dv;
            always_comb begin
                dv      = 64'(r_ts) << B;
                n_st[s] = r_st[s-1];
                if (r_st[s-1].rem >= dv) begin
                    n_st[s].rem    = r_st[s-1].rem - dv;
                    n_st[s].quo[B] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NST; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (w_adv) begin
            r_vld[0] <= i_in_valid && o_in_ready;
            for (int s = 1; s < NST; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    // result assembly and output buffer
    t_res  w_res;
    t_res  r_out;
    t_res  r_skid;
    logic  w_take;

    always_comb begin
        w_res = '0;
        w_res.cell_out  = r_st[NST-1].cell_idx;
        w_res.new_level = r_st[NST-1].z;
        if (r_st[NST-1].applied) begin
            w_res.applied     = 1'b1;
            w_res.new_level   = r_st[NST-1].new_z;
            w_res.water_depth = r_st[NST-1].wdep;
            w_res.is_dry      = r_st[NST-1].dry;
            if (r_ts == 31'd0) begin
                w_res.achieved_rate = '0;
            end else if (r_st[NST-1].sat) begin
                w_res.achieved_rate = MASK31;
            end else begin
                w_res.achieved_rate = r_st[NST-1].quo;
            end
        end
    end

    assign w_take = w_adv && r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_out_vld && i_out_ready) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld <= w_take;
            end
        end else if (w_take) begin
            if (r_out_vld) begin
                r_skid_vld <= 1'b1;
            end else begin
                r_out_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_out_vld && i_out_ready) begin
            if (r_skid_vld) begin
                r_out <= r_skid;
            end else begin
                r_out <= w_res;
            end
        end else if (w_take) begin
            if (r_out_vld) begin
                r_skid <= w_res;
            end else begin
                r_out <= w_res;
            end
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_cell_out      = r_out.cell_out;
    assign o_applied       = r_out.applied;
    assign o_new_level     = r_out.new_level;
    assign o_water_depth   = r_out.water_depth;
    assign o_is_dry        = r_out.is_dry;
    assign o_achieved_rate = r_out.achieved_rate;

    `HICU_ASSERT_IMP(a_no_request_while_clearing, r_clearing, !o_in_ready, "request taken during clear")
    `HICU_ASSERT_IMP(a_no_update_while_clearing, r_clearing, !w_wr_en, "store update during clear")
    `HICU_ASSERT_IMP(a_skid_behind_output, r_skid_vld, r_out_vld, "buffered result without output")
    `HICU_ASSERT_NEXT(a_skid_holds, r_skid_vld && !i_out_ready, r_skid_vld && !o_in_ready, "buffered result lost")

endmodule
